// ===== sv/hkmm_pkg.sv =====
`timescale 1ns / 1ps
package hkmm_pkg;

	localparam int MAX_PIXELS = 65536;
	localparam int KEEP_CAP   = (MAX_PIXELS < 65536) ? MAX_PIXELS : 65536;

	localparam int FIFO_DEPTH = 4;
	localparam int DIV_STEPS  = 16;

	typedef enum logic [2:0] {
		REG_HUE_LOW  = 3'd0,
		REG_HUE_HIGH = 3'd1,
		REG_SAT_LOW  = 3'd2,
		REG_SAT_HIGH = 3'd3,
		REG_VAL_LOW  = 3'd4,
		REG_VAL_HIGH = 3'd5
	} hkmm_reg_e;

	typedef struct packed {
		logic [8:0] hue_low;
		logic [8:0] hue_high;
		logic [6:0] sat_low_pct;
		logic [6:0] sat_high_pct;
		logic [7:0] val_low;
		logic [7:0] val_high;
	} hkmm_cfg_t;

	// classified pixel handed from the front to the back
	typedef struct packed {
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
		logic       last;
		logic       bg;
	} hkmm_item_t;

endpackage

// ===== sv/hkmm_pix_if.sv =====
`timescale 1ns / 1ps
interface hkmm_pix_if;
	logic       valid;
	logic       ready;
	logic [7:0] pixel_blue;
	logic [7:0] pixel_green;
	logic [7:0] pixel_red;
	logic       last_pixel;

	modport source (output valid, pixel_blue, pixel_green, pixel_red, last_pixel, input ready);
	modport sink (input valid, pixel_blue, pixel_green, pixel_red, last_pixel, output ready);
endinterface

// ===== sv/hkmm_res_if.sv =====
`timescale 1ns / 1ps
interface hkmm_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] mean_blue;
	logic [15:0] mean_green;
	logic [15:0] mean_red;
	logic [16:0] kept_count;
	logic        empty_image;

	modport source (output valid, mean_blue, mean_green, mean_red, kept_count, empty_image,
		input ready);
	modport sink (input valid, mean_blue, mean_green, mean_red, kept_count, empty_image,
		output ready);
endinterface

// ===== sv/hkmm_cfg_if.sv =====
`timescale 1ns / 1ps
interface hkmm_cfg_if;
	logic       valid;
	logic       ready;
	logic [2:0] index;
	logic [8:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/hsv_key_masked_mean_color_core.sv =====
`timescale 1ns / 1ps
// HSV chroma-key masked mean color. Each 8-bit BGR pixel is converted to HSV
// and dropped as background when hue, saturation and value all lie strictly
// inside the programmed bounds; the rest are summed per channel and counted.
// The pixel marked last closes the image: one result transfer follows with the
// three means in unsigned 8.8 (floor), the kept count and an empty flag, and
// the accumulators restart. Pixels are taken one per clock while the front
// is not stalled, through a two-stage classify pipeline feeding a four-entry
// queue. At each image end the back end runs a 16-step shift-subtract
// divide and takes no pixel while it runs; the pipeline and queue absorb up
// to six pixels of the next image meanwhile before the front stalls. A result
// that is not taken holds the next image's last pixel. Write the bounds
// only while idle.
module hsv_key_masked_mean_color_core import hkmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	hkmm_pix_if.sink   pix,
	hkmm_res_if.source res,
	hkmm_cfg_if.sink   cfg
);

	hkmm_cfg_t  cfg_q;
	hkmm_item_t cls_item, q_item;
	logic       cls_valid, cls_ready, q_valid, q_ready;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.hue_low      <= 9'd30;
			cfg_q.hue_high     <= 9'd150;
			cfg_q.sat_low_pct  <= 7'd15;
			cfg_q.sat_high_pct <= 7'd75;
			cfg_q.val_low      <= 8'd0;
			cfg_q.val_high     <= 8'd255;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_HUE_LOW:  cfg_q.hue_low      <= cfg.data;
				REG_HUE_HIGH: cfg_q.hue_high     <= cfg.data;
				REG_SAT_LOW:  cfg_q.sat_low_pct  <= cfg.data[6:0];
				REG_SAT_HIGH: cfg_q.sat_high_pct <= cfg.data[6:0];
				REG_VAL_LOW:  cfg_q.val_low      <= cfg.data[7:0];
				REG_VAL_HIGH: cfg_q.val_high     <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	hkmm_classify u_classify (
		.clk,
		.arst_n,
		.cfg        (cfg_q),
		.pix        (pix),
		.item       (cls_item),
		.item_valid (cls_valid),
		.item_ready (cls_ready)
	);

	hkmm_fifo u_fifo (
		.clk,
		.arst_n,
		.push_item  (cls_item),
		.push_valid (cls_valid),
		.push_ready (cls_ready),
		.pop_item   (q_item),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	hkmm_accum u_accum (
		.clk,
		.arst_n,
		.item       (q_item),
		.item_valid (q_valid),
		.item_ready (q_ready),
		.res        (res)
	);

endmodule

// ===== sv/hkmm_classify.sv =====
`timescale 1ns / 1ps
module hkmm_classify import hkmm_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  hkmm_cfg_t       cfg,
	hkmm_pix_if.sink        pix,
	output hkmm_item_t      item,
	output logic            item_valid,
	input  logic            item_ready
);

	typedef enum logic [2:0] {
		SEC_R = 3'b001,
		SEC_G = 3'b010,
		SEC_B = 3'b100
	} sec_t;

	logic en;

	logic [7:0] v0, mn0, d0;
	sec_t       sec0;

	logic       valid_s1;
	logic [7:0] blue_s1, green_s1, red_s1, v_s1, d_s1;
	logic       last_s1;
	sec_t       sec_s1;

	logic [7:0]         hue_x, hue_y, base;
	logic signed [9:0]  diff;
	logic [15:0]        base_d;
	logic signed [18:0] hn_raw, hn_fix, d360;

	logic        valid_s2;
	logic [7:0]  blue_s2, green_s2, red_s2, v_s2;
	logic        last_s2;
	logic [16:0] hn_s2, hlo_d_s2, hhi_d_s2;
	logic [14:0] d100_s2, slo_v_s2, shi_v_s2;

	// the whole pipe moves together; hold when the last stage cannot hand off
	assign en        = !valid_s2 || item_ready;
	assign pix.ready = en;

	always_comb begin
		v0  = pix.pixel_red;
		mn0 = pix.pixel_red;
		if (pix.pixel_green > v0) v0 = pix.pixel_green;
		if (pix.pixel_blue > v0) v0 = pix.pixel_blue;
		if (pix.pixel_green < mn0) mn0 = pix.pixel_green;
		if (pix.pixel_blue < mn0) mn0 = pix.pixel_blue;
		d0 = v0 - mn0;
		if (v0 == pix.pixel_red) sec0 = SEC_R;
		else if (v0 == pix.pixel_green) sec0 = SEC_G;
		else sec0 = SEC_B;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= pix.valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blue_s1  <= pix.pixel_blue;
			green_s1 <= pix.pixel_green;
			red_s1   <= pix.pixel_red;
			last_s1  <= pix.last_pixel;
			v_s1     <= v0;
			d_s1     <= d0;
			sec_s1   <= sec0;
		end
	end

	// hue numerator: H * d, folded into 0..360*d
	always_comb begin
		unique case (sec_s1)
			SEC_R: begin
				hue_x = green_s1;
				hue_y = blue_s1;
				base  = 8'd0;
			end
			SEC_G: begin
				hue_x = blue_s1;
				hue_y = red_s1;
				base  = 8'd120;
			end
			SEC_B: begin
				hue_x = red_s1;
				hue_y = green_s1;
				base  = 8'd240;
			end
			default: begin
				hue_x = 8'd0;
				hue_y = 8'd0;
				base  = 8'd0;
			end
		endcase
		diff   = $signed({2'b00, hue_x}) - $signed({2'b00, hue_y});
		base_d = 16'(base) * 16'(d_s1);
		d360   = $signed({2'b00, 17'(17'(d_s1) * 17'd360)});
		hn_raw = $signed({3'b000, base_d}) + 19'(diff) * 19'sd60;
		hn_fix = hn_raw[18] ? hn_raw + d360 : hn_raw;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			blue_s2  <= blue_s1;
			green_s2 <= green_s1;
			red_s2   <= red_s1;
			last_s2  <= last_s1;
			v_s2     <= v_s1;
			hn_s2    <= hn_fix[16:0];
			hlo_d_s2 <= 17'(cfg.hue_low) * 17'(d_s1);
			hhi_d_s2 <= 17'(cfg.hue_high) * 17'(d_s1);
			d100_s2  <= 15'(d_s1) * 15'd100;
			slo_v_s2 <= 15'(cfg.sat_low_pct) * 15'(v_s1);
			shi_v_s2 <= 15'(cfg.sat_high_pct) * 15'(v_s1);
		end
	end

	assign item_valid = valid_s2;
	assign item.blue  = blue_s2;
	assign item.green = green_s2;
	assign item.red   = red_s2;
	assign item.last  = last_s2;
	assign item.bg    = (hn_s2 > hlo_d_s2) && (hn_s2 < hhi_d_s2)
		&& (d100_s2 > slo_v_s2) && (d100_s2 < shi_v_s2)
		&& (v_s2 > cfg.val_low) && (v_s2 < cfg.val_high);

endmodule

// ===== sv/hkmm_fifo.sv =====
`timescale 1ns / 1ps
module hkmm_fifo import hkmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hkmm_item_t push_item,
	input  logic       push_valid,
	output logic       push_ready,
	output hkmm_item_t pop_item,
	output logic       pop_valid,
	input  logic       pop_ready
);

	localparam int PW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);

	hkmm_item_t    mem_q [FIFO_DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          push, pop;

	assign push_ready = cnt_q != CW'(FIFO_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_item   = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PW'(FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PW'(FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_item;
	end

endmodule

// ===== sv/hkmm_div.sv =====
`timescale 1ns / 1ps
module hkmm_div import hkmm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [23:0] sum,
	input  logic [16:0] divisor,
	output logic [15:0] quo,
	output logic        done
);

	localparam int CW = $clog2(DIV_STEPS + 1);

	logic [CW-1:0] cnt_q;
	logic          done_q;
	logic [16:0]   rem_q, div_q;
	logic [15:0]   lo_q, quo_q;
	logic [17:0]   trial;
	logic          fits;

	// sum/count never exceeds 255, so sum*256/count needs only 16 quotient bits
	assign trial = {rem_q, lo_q[15]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CW'(DIV_STEPS);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= cnt_q == CW'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, sum[23:8]};
			lo_q  <= {sum[7:0], 8'h00};
			div_q <= divisor;
			quo_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q <= fits ? 17'(trial - {1'b0, div_q}) : trial[16:0];
			lo_q  <= {lo_q[14:0], 1'b0};
			quo_q <= {quo_q[14:0], fits};
		end
	end

	assign quo  = quo_q;
	assign done = done_q;

endmodule

// ===== sv/hkmm_accum.sv =====
`timescale 1ns / 1ps
module hkmm_accum import hkmm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  hkmm_item_t item,
	input  logic       item_valid,
	output logic       item_ready,
	hkmm_res_if.source res
);

	typedef enum logic [1:0] {
		ST_ACC = 2'b01,
		ST_DIV = 2'b10
	} state_t;

	typedef struct packed {
		logic [15:0] mean_blue;
		logic [15:0] mean_green;
		logic [15:0] mean_red;
		logic [16:0] kept_count;
		logic        empty_image;
	} res_t;

	state_t      state_q;
	logic [23:0] sum_b_q, sum_g_q, sum_r_q;
	logic [23:0] sum_b_nx, sum_g_nx, sum_r_nx;
	logic [16:0] count_q, count_nx, res_cnt_q;
	logic        take, pop, start;
	logic [15:0] quo_b, quo_g, quo_r;
	logic        done_b, done_g, done_r;
	res_t        res_q;
	logic        res_valid_q;

	// hold a last pixel while the previous result is still waiting
	assign item_ready = (state_q == ST_ACC) && !(item.last && res_valid_q);
	assign pop        = item_valid && item_ready;
	assign start      = pop && item.last;

	always_comb begin
		take     = !item.bg && (count_q < 17'(KEEP_CAP));
		sum_b_nx = take ? sum_b_q + 24'(item.blue) : sum_b_q;
		sum_g_nx = take ? sum_g_q + 24'(item.green) : sum_g_q;
		sum_r_nx = take ? sum_r_q + 24'(item.red) : sum_r_q;
		count_nx = take ? count_q + 1'b1 : count_q;
	end

	hkmm_div u_div_b (.clk, .arst_n, .start, .sum(sum_b_nx), .divisor(count_nx),
		.quo(quo_b), .done(done_b));
	hkmm_div u_div_g (.clk, .arst_n, .start, .sum(sum_g_nx), .divisor(count_nx),
		.quo(quo_g), .done(done_g));
	hkmm_div u_div_r (.clk, .arst_n, .start, .sum(sum_r_nx), .divisor(count_nx),
		.quo(quo_r), .done(done_r));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			sum_b_q     <= '0;
			sum_g_q     <= '0;
			sum_r_q     <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_ACC: begin
					if (pop) begin
						if (item.last) begin
							sum_b_q <= '0;
							sum_g_q <= '0;
							sum_r_q <= '0;
							count_q <= '0;
							state_q <= ST_DIV;
						end else begin
							sum_b_q <= sum_b_nx;
							sum_g_q <= sum_g_nx;
							sum_r_q <= sum_r_nx;
							count_q <= count_nx;
						end
					end
				end
				ST_DIV: begin
					if (done_b) begin
						res_valid_q <= 1'b1;
						state_q     <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
			if (res_valid_q && res.ready) res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) res_cnt_q <= count_nx;
		if (state_q == ST_DIV && done_b && done_g && done_r) begin
			res_q.kept_count  <= res_cnt_q;
			res_q.empty_image <= res_cnt_q == '0;
			res_q.mean_blue   <= (res_cnt_q == '0) ? '0 : quo_b;
			res_q.mean_green  <= (res_cnt_q == '0) ? '0 : quo_g;
			res_q.mean_red    <= (res_cnt_q == '0) ? '0 : quo_r;
		end
	end

	assign res.valid       = res_valid_q;
	assign res.mean_blue   = res_q.mean_blue;
	assign res.mean_green  = res_q.mean_green;
	assign res.mean_red    = res_q.mean_red;
	assign res.kept_count  = res_q.kept_count;
	assign res.empty_image = res_q.empty_image;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 17'(KEEP_CAP))
		else $error("kept count beyond cap");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && res_q.empty_image |-> res_q.kept_count == '0
			&& res_q.mean_blue == '0 && res_q.mean_green == '0 && res_q.mean_red == '0)
		else $error("empty result carries nonzero fields");

	a_res_from_div: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == ST_DIV) && $past(done_b))
		else $error("result raised outside a finished divide");

endmodule
